/* hdl/reach_limited_bipartite_matching_defines.svh */
// Assertion macros used by the checker file.
`ifndef REACH_LIMITED_BIPARTITE_MATCHING_DEFINES_SVH
`define REACH_LIMITED_BIPARTITE_MATCHING_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define RLBM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Assert that a condition implies a consequence in the next cycle.
`define RLBM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* hdl/rlbm_pkg.sv */
// ----------------------------------------------------------------------------
// rlbm_pkg
// Types, constants and codes shared by the matching block.
// ----------------------------------------------------------------------------
`default_nettype none
package rlbm_pkg;
	localparam int MAX_SOURCES_DEF = 64;
	localparam int MAX_TARGETS_DEF = 64;
	localparam int FRAC_BITS_DEF   = 8;
	localparam int COORD_W = 24;
	localparam int CMD_W   = 2;
	localparam int CNT_W   = 7;
	localparam int REG_W   = 16;
	localparam int IDX_W   = 1;
	localparam int FIFO_DEPTH = 4;

	localparam logic [CMD_W-1:0] CMD_LOAD_SRC = 2'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD_TGT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SOLVE    = 2'd2;

	localparam logic [IDX_W-1:0] REG_TIME_LIMIT = 1'b0;
	localparam logic [IDX_W-1:0] REG_SPEED      = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic signed [COORD_W-1:0] x_coord;
		logic signed [COORD_W-1:0] y_coord;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0] unmatched_count;
		logic [CNT_W-1:0] matched_count;
		logic             overflow;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_EDGE_RD, ST_EDGE_MUL, ST_EDGE_SUM, ST_EDGE_CMP,
		ST_AUG_START, ST_SCAN, ST_POP, ST_PUSH_RD, ST_COMMIT, ST_NEXT_SRC, ST_EMIT
	} eng_state_t;
endpackage
`default_nettype wire

/* hdl/reach_limited_bipartite_matching.sv */
// ----------------------------------------------------------------------------
// reach_limited_bipartite_matching
// Maximum bipartite matching between loaded points within a travel reach.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// s_axis    in   tdata: command[1:0], x_coord[25:2], y_coord[49:26]
// m_axis    out  tdata: unmatched_count[6:0], matched_count[13:7], overflow[14]
// cfg       in   wr_en, wr_index, wr_data (0 time_limit, 1 speed)
// Requests queue in a four-entry FIFO.
// A solve first builds the edge rows, then runs the augmenting search per source:
// target probes, pushes, pops and owner updates.
// Reset clears counts, owner flags, the result and the FIFO at once.
// A solve waits at the queue head while a result is pending on m_axis.
`default_nettype none
module reach_limited_bipartite_matching #(
	parameter int MAX_SOURCES = rlbm_pkg::MAX_SOURCES_DEF,
	parameter int MAX_TARGETS = rlbm_pkg::MAX_TARGETS_DEF,
	parameter int FRAC_BITS   = rlbm_pkg::FRAC_BITS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire [55:0]  s_axis_tdata,   // command, x_coord, y_coord, zero pad
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [15:0] m_axis_tdata,   // unmatched_count, matched_count, overflow, pad
	input  wire         wr_en,
	input  wire [rlbm_pkg::IDX_W-1:0] wr_index,
	input  wire [rlbm_pkg::REG_W-1:0] wr_data
);
	import rlbm_pkg::*;
	req_t in_req, q_req;
	res_t res;
	logic q_valid, q_ready;
	logic [REG_W-1:0] time_limit_q, speed_q;

	assign in_req.command = s_axis_tdata[1:0];
	assign in_req.x_coord = s_axis_tdata[25:2];
	assign in_req.y_coord = s_axis_tdata[49:26];
	assign m_axis_tdata = {1'b0, res.overflow, res.matched_count, res.unmatched_count};

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_limit_q <= '0; speed_q <= REG_W'(1);
		end else if (wr_en) begin
			if (wr_index == REG_TIME_LIMIT) time_limit_q <= wr_data;
			else if (wr_index == REG_SPEED) speed_q <= wr_data;
		end
	end

	rlbm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req));

	rlbm_engine #(.MAX_SOURCES(MAX_SOURCES), .MAX_TARGETS(MAX_TARGETS),
		.FRAC_BITS(FRAC_BITS)) u_engine (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.time_limit(time_limit_q), .speed(speed_q), .res_valid(m_axis_tvalid),
		.res_ready(m_axis_tready), .res(res));
endmodule
`default_nettype wire

/* hdl/rlbm_front.sv */
// ----------------------------------------------------------------------------
// rlbm_front
// Accepts requests and queues them in a short FIFO for the engine.
// ----------------------------------------------------------------------------
`default_nettype none
module rlbm_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_ready,
	input  rlbm_pkg::req_t      in_req,
	output logic                q_valid,
	input  wire                 q_ready,
	output rlbm_pkg::req_t      q_req
);
	import rlbm_pkg::*;
	localparam int PW = $clog2(FIFO_DEPTH);

	req_t            mem_q [FIFO_DEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;
	logic            push, pop;

	assign in_ready = (cnt_q != PW'(0) + (PW+1)'(FIFO_DEPTH));
	assign q_valid  = (cnt_q != '0);
	assign q_req    = mem_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	// Store pushed requests
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_req;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + PW'(1);
			if (pop) rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end
endmodule
`default_nettype wire

/* hdl/rlbm_engine.sv */
// ----------------------------------------------------------------------------
// rlbm_engine
// Stores points, builds edge rows and runs augmenting-path matching.
// ----------------------------------------------------------------------------
`default_nettype none
module rlbm_engine #(
	parameter int MAX_SOURCES = rlbm_pkg::MAX_SOURCES_DEF,
	parameter int MAX_TARGETS = rlbm_pkg::MAX_TARGETS_DEF,
	parameter int FRAC_BITS   = rlbm_pkg::FRAC_BITS_DEF
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         q_valid,
	output logic                        q_ready,
	input  rlbm_pkg::req_t              q_req,
	input  wire [rlbm_pkg::REG_W-1:0]   time_limit,
	input  wire [rlbm_pkg::REG_W-1:0]   speed,
	output logic                        res_valid,
	input  wire                         res_ready,
	output rlbm_pkg::res_t              res
);
	import rlbm_pkg::*;
	localparam int SW  = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
	localparam int TW  = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
	localparam int SCW = $clog2(MAX_SOURCES + 1);
	localparam int TCW = $clog2(MAX_TARGETS + 1);
	localparam int DW  = 2 * COORD_W + 1;
	localparam int RW  = 2 * REG_W + FRAC_BITS;
	// reach at or above 2^RBW covers any distance
	localparam int RBW = 26;
	localparam logic [RW-1:0] REACH_ALWAYS = RW'(1) << RBW;
	localparam int STK = MAX_TARGETS + 1;
	localparam int KW  = $clog2(STK + 1);

	// Point stores (x in high half)
	logic [2*COORD_W-1:0] src_mem [MAX_SOURCES];
	logic [2*COORD_W-1:0] tgt_mem [MAX_TARGETS];
	logic [MAX_TARGETS-1:0] edge_mem [MAX_SOURCES];
	logic [SW-1:0] owner_q [MAX_TARGETS];
	logic [MAX_TARGETS-1:0] owner_valid_q, visited_q;
	logic [SW-1:0] stk_src_q  [STK];
	logic [TW:0]   stk_next_q [STK];
	logic [TW-1:0] stk_pick_q [STK];

	logic [SCW-1:0] scnt_q;
	logic [TCW-1:0] tcnt_q;
	logic           ovf_q;
	eng_state_t     st_q, st_d;
	logic [SW-1:0]  i_q;
	logic [TW:0]    j_q;
	logic [KW-1:0]  top_q, k_q;
	logic [CNT_W-1:0] matched_q;
	logic [2*COORD_W-1:0] sp_q, tp_q;
	logic [DW-1:0]  dx2_q, dy2_q, d2_q;
	logic [RW-1:0]  r_q;
	logic [2*RBW-1:0] r2_q;
	logic [MAX_TARGETS-1:0] row_q, cur_row_q;
	logic [SW-1:0]  cur_src_q;
	logic [TW:0]    v_q;
	logic           res_valid_q;
	res_t           res_q;
	logic [SW-1:0]  own_rd_q;
	logic [SW-1:0]  stk_rd_src_q;
	logic [TW:0]    stk_rd_next_q;
	logic [TW-1:0]  stk_rd_pick_q;

	logic signed [COORD_W:0] dx, dy;
	logic [COORD_W-1:0] ax, ay;
	assign dx = {sp_q[2*COORD_W-1], sp_q[2*COORD_W-1:COORD_W]}
		- {tp_q[2*COORD_W-1], tp_q[2*COORD_W-1:COORD_W]};
	assign dy = {sp_q[COORD_W-1], sp_q[COORD_W-1:0]} - {tp_q[COORD_W-1], tp_q[COORD_W-1:0]};
	assign ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
	assign ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

	// Pair within reach
	logic link_hit;
	assign link_hit = (r_q >= REACH_ALWAYS) || ((2*RBW)'(d2_q) <= r2_q);

	// Current scan position hit: edge present, not visited
	logic [TW-1:0] vi;
	logic          hit;
	assign vi  = v_q[TW-1:0];
	assign hit = cur_row_q[vi] && !visited_q[vi];

	// Stack read address: next frame to commit, else parent of the top frame
	logic [KW-1:0] stk_ra;
	assign stk_ra = (st_q == ST_COMMIT) ? ((k_q != '0) ? k_q - KW'(1) : '0)
		: ((top_q != '0) ? top_q - KW'(1) : '0);

	// Edge row read address for the frame that becomes current
	logic [SW-1:0] row_addr;
	assign row_addr = (st_q == ST_PUSH_RD) ? own_rd_q
		: (st_q == ST_POP) ? stk_rd_src_q : cur_src_q;

	// Hold a solve while a result waits; loads pass
	assign q_ready   = (st_q == ST_IDLE) && (!res_valid_q || q_req.command != CMD_SOLVE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (q_valid && q_ready && q_req.command == CMD_SOLVE) begin
				st_d = (scnt_q != '0 && tcnt_q != '0) ? ST_EDGE_RD : ST_EMIT;
			end
			ST_EDGE_RD:  st_d = ST_EDGE_MUL;
			ST_EDGE_MUL: st_d = ST_EDGE_SUM;
			ST_EDGE_SUM: st_d = ST_EDGE_CMP;
			ST_EDGE_CMP: begin
				if (j_q + (TW+1)'(1) < (TW+1)'(tcnt_q)) st_d = ST_EDGE_RD;
				else if (SCW'(i_q) + SCW'(1) < scnt_q) st_d = ST_EDGE_RD;
				else st_d = ST_AUG_START;
			end
			ST_AUG_START: st_d = ST_SCAN;
			ST_SCAN: begin
				if (v_q >= (TW+1)'(tcnt_q)) st_d = ST_POP;
				else if (hit) begin
					if (owner_valid_q[vi]) st_d = ST_PUSH_RD;
					else st_d = (top_q == '0) ? ST_NEXT_SRC : ST_COMMIT;
				end
			end
			ST_POP:     st_d = (top_q == '0) ? ST_NEXT_SRC : ST_SCAN;
			ST_PUSH_RD: st_d = ST_SCAN;
			ST_COMMIT:  st_d = (k_q == '0) ? ST_NEXT_SRC : ST_COMMIT;
			ST_NEXT_SRC: st_d = (SCW'(i_q) + SCW'(1) < scnt_q) ? ST_AUG_START : ST_EMIT;
			ST_EMIT:    st_d = ST_IDLE;
			default:    st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= ST_IDLE;
		else st_q <= st_d;
	end

	// Memories and datapath
	always_ff @(posedge clk) begin
		if (st_q == ST_IDLE && q_valid && q_ready) begin
			if (q_req.command == CMD_LOAD_SRC && scnt_q < SCW'(MAX_SOURCES))
				src_mem[scnt_q[SW-1:0]] <= {q_req.x_coord, q_req.y_coord};
			if (q_req.command == CMD_LOAD_TGT && tcnt_q < TCW'(MAX_TARGETS))
				tgt_mem[tcnt_q[TW-1:0]] <= {q_req.x_coord, q_req.y_coord};
		end
		sp_q <= src_mem[i_q];
		tp_q <= tgt_mem[j_q[TW-1:0]];
		dx2_q <= DW'(ax) * DW'(ax);
		dy2_q <= DW'(ay) * DW'(ay);
		d2_q  <= dx2_q + dy2_q;
		r_q   <= (RW'(time_limit) * RW'(speed)) << FRAC_BITS;
		r2_q  <= (2*RBW)'(r_q[RBW-1:0]) * (2*RBW)'(r_q[RBW-1:0]);
		if (st_q == ST_EDGE_CMP) begin
			if (j_q + (TW+1)'(1) >= (TW+1)'(tcnt_q))
				edge_mem[i_q] <= row_q | (link_hit
					? (MAX_TARGETS'(1) << j_q[TW-1:0]) : '0);
		end
		if (st_q == ST_AUG_START || st_q == ST_PUSH_RD || st_q == ST_POP)
			cur_row_q <= edge_mem[row_addr];
		own_rd_q      <= owner_q[vi];
		stk_rd_src_q  <= stk_src_q[stk_ra];
		stk_rd_next_q <= stk_next_q[stk_ra];
		stk_rd_pick_q <= stk_pick_q[stk_ra];
		if (st_q == ST_AUG_START)
			stk_src_q[0] <= i_q;
		if (st_q == ST_SCAN && v_q < (TW+1)'(tcnt_q) && hit) begin
			stk_next_q[top_q] <= v_q + (TW+1)'(1);
			stk_pick_q[top_q] <= vi;
			if (!owner_valid_q[vi]) owner_q[vi] <= cur_src_q;
		end
		if (st_q == ST_PUSH_RD)
			stk_src_q[top_q] <= own_rd_q;
		if (st_q == ST_COMMIT)
			owner_q[stk_rd_pick_q] <= stk_rd_src_q;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scnt_q <= '0; tcnt_q <= '0; ovf_q <= 1'b0;
			i_q <= '0; j_q <= '0; top_q <= '0; k_q <= '0; v_q <= '0;
			matched_q <= '0; row_q <= '0; owner_valid_q <= '0; visited_q <= '0;
			cur_src_q <= '0; res_valid_q <= 1'b0; res_q <= '0;
		end else begin
			if (res_valid_q && res_ready) res_valid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (q_valid && q_ready) begin
					i_q <= '0; j_q <= '0; row_q <= '0; matched_q <= '0;
					owner_valid_q <= '0;
					if (q_req.command == CMD_LOAD_SRC) begin
						if (scnt_q < SCW'(MAX_SOURCES)) scnt_q <= scnt_q + SCW'(1);
						else ovf_q <= 1'b1;
					end else if (q_req.command == CMD_LOAD_TGT) begin
						if (tcnt_q < TCW'(MAX_TARGETS)) tcnt_q <= tcnt_q + TCW'(1);
						else ovf_q <= 1'b1;
					end
				end
				ST_EDGE_CMP: begin
					if (j_q + (TW+1)'(1) < (TW+1)'(tcnt_q)) begin
						j_q <= j_q + (TW+1)'(1);
						if (link_hit)
							row_q <= row_q | (MAX_TARGETS'(1) << j_q[TW-1:0]);
					end else begin
						j_q <= '0; row_q <= '0;
						if (SCW'(i_q) + SCW'(1) < scnt_q) i_q <= i_q + SW'(1);
						else begin i_q <= '0; cur_src_q <= '0; end
					end
				end
				ST_AUG_START: begin
					visited_q <= '0; top_q <= '0; v_q <= '0;
				end
				ST_SCAN: begin
					if (v_q < (TW+1)'(tcnt_q)) begin
						if (hit) begin
							visited_q[vi] <= 1'b1;
							if (owner_valid_q[vi]) begin
								top_q <= top_q + KW'(1);
							end else begin
								owner_valid_q[vi] <= 1'b1;
								if (top_q == '0) matched_q <= matched_q + CNT_W'(1);
								else k_q <= top_q - KW'(1);
							end
						end else v_q <= v_q + (TW+1)'(1);
					end
				end
				ST_POP: if (top_q != '0) begin
					top_q <= top_q - KW'(1);
					cur_src_q <= stk_rd_src_q;
					v_q <= stk_rd_next_q;
				end
				ST_PUSH_RD: begin
					cur_src_q <= own_rd_q;
					v_q <= '0;
				end
				ST_COMMIT: begin
					if (k_q == '0) matched_q <= matched_q + CNT_W'(1);
					else k_q <= k_q - KW'(1);
				end
				ST_NEXT_SRC: begin
					i_q <= i_q + SW'(1);
					cur_src_q <= i_q + SW'(1);
				end
				ST_EMIT: begin
					res_valid_q <= 1'b1;
					res_q.matched_count   <= matched_q;
					res_q.unmatched_count <= CNT_W'(scnt_q) - matched_q;
					res_q.overflow        <= ovf_q;
					scnt_q <= '0; tcnt_q <= '0; ovf_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

/* hdl/rlbm_checker.sv */
// ----------------------------------------------------------------------------
// rlbm_checker
// Port-level checks for the matching block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "reach_limited_bipartite_matching_defines.svh"
module rlbm_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [15:0] m_axis_tdata
);
	// Counts never exceed capacity and padding stays zero
	`RLBM_ASSERT_IMP(a_pad, clk, arst_n, m_axis_tvalid, m_axis_tdata[15] == 1'b0)
	`RLBM_ASSERT_IMP(a_sum, clk, arst_n, m_axis_tvalid,
		({1'b0, m_axis_tdata[6:0]} + {1'b0, m_axis_tdata[13:7]}) <= 8'd64)
	// Stalled result holds
	`RLBM_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind reach_limited_bipartite_matching rlbm_checker u_chk (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));
`default_nettype wire
